>>> rtl/fkr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fkr_pkg: shared types and constants for the keyed FIFO
// Holds the queue geometry, the operation and status codes, the request and
// response item layouts, and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
package fkr_pkg;

	// Queue geometry and stored field widths.
	localparam int DEPTH        = 16;
	localparam int ID_WIDTH     = 16;
	localparam int HANDLE_WIDTH = 32;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int CNT_W        = $clog2(DEPTH + 1);

	// Operation codes carried by a request item.
	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_FIND   = 2'd2,
		OP_REMOVE = 2'd3
	} op_e;

	// Status codes carried by a response item.
	typedef enum logic [1:0] {
		RS_DONE = 2'd0,
		RS_MISS = 2'd1,
		RS_FULL = 2'd2
	} status_e;

	// Request item.
	typedef struct packed {
		op_e         operation;
		logic [15:0] entry_id;
		logic [31:0] entry_handle;
	} req_t;

	// Response item.
	typedef struct packed {
		status_e     status;
		logic [31:0] out_handle;
		logic        queue_empty;
		logic [4:0]  entry_count;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage
`default_nettype wire

>>> rtl/fkr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fkr_ctrl: sequencing controller for the keyed FIFO
// Takes one request item, lets the datapath register its search, then
// commits the update and loads the response register once it is free.
// ----------------------------------------------------------------------------
module fkr_ctrl
	import fkr_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  wire  logic rsp_ready,
	output cmd_t       cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_e;

	state_e state_q;
	state_e state_d;
	logic   rsp_valid_q;
	logic   rsp_free;

	// The response register may be reloaded when empty or when drained now.
	assign rsp_free    = !rsp_valid_q || rsp_ready;
	assign req_ready   = (state_q == S_IDLE);
	assign cmd.capture = req_valid && req_ready;
	assign cmd.commit  = (state_q == S_EXEC) && rsp_free;
	assign rsp_valid   = rsp_valid_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.commit) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and response-valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/fkr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fkr_dp: storage, search and compaction datapath for the keyed FIFO
// Slots are kept oldest first. On capture all slots are compared with the
// key; on commit a put fills the tail, a get or remove takes the head or
// oldest hit, slots above it shift down one place, and rsp_q is loaded.
// ----------------------------------------------------------------------------
module fkr_dp
	import fkr_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  cmd_t cmd,
	input  wire  req_t req,
	output rsp_t       rsp
);

	logic [ID_WIDTH-1:0]     ids_q [DEPTH];
	logic [HANDLE_WIDTH-1:0] hdls_q [DEPTH];
	logic [CNT_W-1:0]        count_q;
	op_e                     op_q;
	logic [ID_WIDTH-1:0]     key_q;
	logic [HANDLE_WIDTH-1:0] hdl_in_q;
	logic [DEPTH-1:0]        hit_q;
	rsp_t                    rsp_q;

	logic [ID_WIDTH-1:0]     key_in;
	logic [DEPTH-1:0]        hit_d;
	logic [DEPTH-1:0]        first_oh;
	logic [DEPTH-1:0]        sel_oh;
	logic [DEPTH-1:0]        shift_mask;
	logic [DEPTH-1:0]        wr_oh;
	logic [HANDLE_WIDTH-1:0] find_hdl;
	logic                    any_hit;
	logic                    is_full;
	logic                    is_empty;
	logic                    do_put;
	logic                    do_drop;
	logic [CNT_W-1:0]        count_d;
	rsp_t                    rsp_d;

	assign key_in = ID_WIDTH'(req.entry_id);

	// Compare every occupied slot with the incoming key.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			hit_d[i] = (ids_q[i] == key_in) && (CNT_W'(i) < count_q);
		end
	end

	// Oldest hit as a one-hot vector and the handle it selects.
	assign first_oh = hit_q & (~hit_q + DEPTH'(1));
	assign any_hit  = |hit_q;

	always_comb begin
		find_hdl = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_oh[i]) find_hdl = find_hdl | hdls_q[i];
		end
	end

	// Decode the update for the captured operation.
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign do_put   = (op_q == OP_PUT) && !is_full;
	assign do_drop  = ((op_q == OP_GET) && !is_empty) || ((op_q == OP_REMOVE) && any_hit);
	assign sel_oh   = (op_q == OP_GET) ? DEPTH'(1) : first_oh;
	assign shift_mask = do_drop ? ~(sel_oh - DEPTH'(1)) : '0;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			wr_oh[i] = do_put && (count_q == CNT_W'(i));
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_put) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_drop) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	// Response fields.
	always_comb begin
		rsp_d.status     = RS_DONE;
		rsp_d.out_handle = '0;
		case (op_q)
			OP_PUT: begin
				if (is_full) rsp_d.status = RS_FULL;
			end
			OP_GET: begin
				if (is_empty) rsp_d.status = RS_MISS;
				else rsp_d.out_handle = 32'(hdls_q[0]);
			end
			OP_FIND: begin
				if (!any_hit) rsp_d.status = RS_MISS;
				else rsp_d.out_handle = 32'(find_hdl);
			end
			default: begin
				if (!any_hit) rsp_d.status = RS_MISS;
			end
		endcase
		rsp_d.queue_empty = (count_d == '0);
		rsp_d.entry_count = 5'(count_d);
	end

	// Captured request and search result.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= req.operation;
			key_q    <= key_in;
			hdl_in_q <= HANDLE_WIDTH'(req.entry_handle);
			hit_q    <= hit_d;
		end
		if (cmd.commit) rsp_q <= rsp_d;
	end

	// Occupancy counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	// A slot takes its younger neighbor or a new entry; the top only a new one.
	for (genvar g = 0; g < DEPTH; g++) begin : g_slot
		if (g < DEPTH - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (cmd.commit) begin
					if (shift_mask[g]) begin
						ids_q[g]  <= ids_q[g+1];
						hdls_q[g] <= hdls_q[g+1];
					end else if (wr_oh[g]) begin
						ids_q[g]  <= key_q;
						hdls_q[g] <= hdl_in_q;
					end
				end
			end
		end else begin : g_top
			always_ff @(posedge clk) begin
				if (cmd.commit && wr_oh[g]) begin
					ids_q[g]  <= key_q;
					hdls_q[g] <= hdl_in_q;
				end
			end
		end
	end

	assign rsp = rsp_q;

	// The count never passes the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	// A put into a full queue leaves the count alone.
	a_full_put: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == OP_PUT) && is_full |=> count_q == $past(count_q))
		else $error("dropped put changed occupancy");

	// The empty flag of a fresh response agrees with the updated count.
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_q.queue_empty == (count_q == '0))
		else $error("empty flag disagrees with occupancy");

endmodule
`default_nettype wire

>>> rtl/fifo_with_key_removal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_with_key_removal: bounded FIFO with search and delete by identifier
// Top level joining the sequencing controller and the storage datapath.
// ----------------------------------------------------------------------------
// Each request item is a put, get, find or remove and yields exactly one
// response item with status, handle, empty flag and entry count. In the
// accept cycle every slot is compared with the key and the match vector
// is registered; in the commit cycle a put fills the tail, a get or remove
// drops the head or the oldest match, the slots above it shift down one
// place, and the response register is loaded. The commit cycle waits while
// the previous response is still held; a new item is accepted only after
// the last one commits. No clearing pass is needed after reset.
module fifo_with_key_removal
	import fkr_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic req_valid,
	output logic       req_ready,
	input  wire  req_t req,
	output logic       rsp_valid,
	input  wire  logic rsp_ready,
	output rsp_t       rsp
);

	cmd_t cmd;

	// Controller.
	fkr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// Datapath.
	fkr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
